[design/go_back_n_sender_window_defines.svh]
// assertion macros for the go-back-n sender window
// used by gbn_ctrl; expects i_clk and i_rst_n in the including module
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// same-cycle implication, held off during reset
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/gbn_pkg.sv]
// shared constants, types and helper functions of the go-back-n sender window
// no dependencies
package gbn_pkg;

    localparam int SEQ_COUNT = 16;
    localparam int SEQ_W     = $clog2(SEQ_COUNT);
    localparam int ACK_W     = SEQ_W + 1;
    localparam int WIN_W     = 4;
    localparam int TMO_W     = 8;
    localparam int PKT_W     = 16;
    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(8);
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(20);

    localparam logic [REG_IDX_W-1:0] REG_WINDOW  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = REG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_POLL = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    // window clamped to one below the sequence space
    function automatic logic [SEQ_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
        if (int'(ws) > SEQ_COUNT - 1) begin
            return SEQ_W'(SEQ_COUNT - 1);
        end
        return SEQ_W'(ws);
    endfunction

    // forward distance from one sequence number to another, modulo the space
    function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from_seq,
                                                  input logic [SEQ_W-1:0] to_seq);
        logic [SEQ_W:0] d;
        d = {1'b0, to_seq} + (SEQ_W+1)'(SEQ_COUNT) - {1'b0, from_seq};
        if (d >= (SEQ_W+1)'(SEQ_COUNT)) begin
            d = d - (SEQ_W+1)'(SEQ_COUNT);
        end
        return d[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        if (s == SEQ_W'(SEQ_COUNT - 1)) begin
            return '0;
        end
        return s + SEQ_W'(1);
    endfunction

endpackage

[design/gbn_cfg.sv]
// configuration registers (window size, timeout limit) behind the apb-style port
// depends on gbn_pkg
module gbn_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbn_pkg::DATA_W-1:0]  pwdata,
    output logic [gbn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [gbn_pkg::WIN_W-1:0]   o_window_size,
    output logic [gbn_pkg::TMO_W-1:0]   o_timeout_limit
);
    import gbn_pkg::*;

    logic [WIN_W-1:0]     r_window_size;
    logic [TMO_W-1:0]     r_timeout_limit;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= WINDOW_RESET;
            r_timeout_limit <= TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WINDOW:  r_window_size   <= pwdata[WIN_W-1:0];
                REG_TIMEOUT: r_timeout_limit <= pwdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_WINDOW:  prdata = DATA_W'(r_window_size);
            REG_TIMEOUT: prdata = DATA_W'(r_timeout_limit);
            default:     prdata = '0;
        endcase
    end

    assign o_window_size   = r_window_size;
    assign o_timeout_limit = r_timeout_limit;

endmodule

[design/gbn_dp.sv]
// datapath: window state, event evaluation and result register
// depends on gbn_pkg; driven by gbn_ctrl commands
module gbn_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbn_pkg::t_dp_cmd            i_cmd,
    input  logic [gbn_pkg::OP_W-1:0]    i_operation,
    input  logic [gbn_pkg::ACK_W-1:0]   i_ack_value,
    input  logic [gbn_pkg::WIN_W-1:0]   i_window_size,
    input  logic [gbn_pkg::TMO_W-1:0]   i_timeout_limit,
    output logic                        o_sent,
    output logic [gbn_pkg::SEQ_W-1:0]   o_sent_seq,
    output logic [gbn_pkg::PKT_W-1:0]   o_packet_index,
    output logic                        o_timeout_fired,
    output logic [gbn_pkg::SEQ_W-1:0]   o_window_base
);
    import gbn_pkg::*;

    // captured event
    logic [OP_W-1:0]      r_op;
    logic [ACK_W-1:0]     r_ack;

    // window state
    logic [SEQ_COUNT-1:0] r_free_map, n_free_map;
    logic [SEQ_W-1:0]     r_base_seq, n_base_seq;
    logic [SEQ_W-1:0]     r_next_seq, n_next_seq;
    logic [PKT_W-1:0]     r_pkt_count, n_pkt_count;
    logic [TMO_W-1:0]     r_idle_count, n_idle_count;

    // result register
    logic                 r_sent, n_sent;
    logic [SEQ_W-1:0]     r_sent_seq, n_sent_seq;
    logic [PKT_W-1:0]     r_packet_index, n_packet_index;
    logic                 r_timeout_fired, n_timeout_fired;

    logic [SEQ_W-1:0]     win;
    logic [SEQ_W-1:0]     outstanding;
    logic [SEQ_W-1:0]     ack_idx;
    logic [SEQ_W-1:0]     ack_off;
    logic                 ack_ok;
    logic [TMO_W:0]       idle_inc;
    logic [SEQ_COUNT-1:0] ack_mask;
    logic [SEQ_COUNT-1:0] tmo_mask;
    logic [SEQ_COUNT-1:0] reset_map;

    assign win         = eff_window(i_window_size);
    assign outstanding = seq_dist(r_base_seq, r_next_seq);
    assign ack_idx     = SEQ_W'(r_ack - ACK_W'(1));
    assign ack_off     = seq_dist(r_base_seq, ack_idx);
    assign ack_ok      = (r_ack >= ACK_W'(1)) && (r_ack <= ACK_W'(SEQ_COUNT))
                         && (ack_off < outstanding);
    assign idle_inc    = {1'b0, r_idle_count} + (TMO_W+1)'(1);

    // per-entry masks from distance to base
    always_comb begin
        for (int j = 0; j < SEQ_COUNT; j++) begin
            ack_mask[j]  = seq_dist(r_base_seq, SEQ_W'(j)) <= ack_off;
            tmo_mask[j]  = seq_dist(r_base_seq, SEQ_W'(j)) < win;
            reset_map[j] = j < int'(eff_window(WINDOW_RESET));
        end
    end

    always_comb begin
        n_free_map      = r_free_map;
        n_base_seq      = r_base_seq;
        n_next_seq      = r_next_seq;
        n_pkt_count     = r_pkt_count;
        n_idle_count    = r_idle_count;
        n_sent          = 1'b0;
        n_sent_seq      = '0;
        n_packet_index  = '0;
        n_timeout_fired = 1'b0;
        case (t_op'(r_op))
            OP_SEND: begin
                if (outstanding < win && r_free_map[r_next_seq]) begin
                    n_sent                 = 1'b1;
                    n_sent_seq             = r_next_seq;
                    n_packet_index         = r_pkt_count;
                    n_free_map[r_next_seq] = 1'b0;
                    n_next_seq             = seq_inc(r_next_seq);
                    n_pkt_count            = r_pkt_count + PKT_W'(1);
                end
            end
            OP_ACK: begin
                n_idle_count = '0;
                if (ack_ok) begin
                    n_free_map = r_free_map | ack_mask;
                    n_base_seq = seq_inc(ack_idx);
                end
            end
            OP_POLL: begin
                if (idle_inc > {1'b0, i_timeout_limit}) begin
                    n_timeout_fired = 1'b1;
                    n_free_map      = r_free_map | tmo_mask;
                    n_pkt_count     = r_pkt_count - PKT_W'(outstanding);
                    n_next_seq      = r_base_seq;
                    n_idle_count    = '0;
                end else begin
                    n_idle_count = idle_inc[TMO_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map   <= reset_map;
            r_base_seq   <= '0;
            r_next_seq   <= '0;
            r_pkt_count  <= '0;
            r_idle_count <= '0;
        end else if (i_cmd.commit) begin
            r_free_map   <= n_free_map;
            r_base_seq   <= n_base_seq;
            r_next_seq   <= n_next_seq;
            r_pkt_count  <= n_pkt_count;
            r_idle_count <= n_idle_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_ack <= i_ack_value;
        end
        if (i_cmd.commit) begin
            r_sent          <= n_sent;
            r_sent_seq      <= n_sent_seq;
            r_packet_index  <= n_packet_index;
            r_timeout_fired <= n_timeout_fired;
        end
    end

    assign o_sent          = r_sent;
    assign o_sent_seq      = r_sent_seq;
    assign o_packet_index  = r_packet_index;
    assign o_timeout_fired = r_timeout_fired;
    assign o_window_base   = r_base_seq;

endmodule

[design/gbn_ctrl.sv]
// controller: two-state sequencer and result-valid flag
// depends on gbn_pkg and go_back_n_sender_window_defines.svh
`include "go_back_n_sender_window_defines.svh"

module gbn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gbn_pkg::t_dp_cmd  o_cmd
);
    import gbn_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_accept;
    logic   out_free;
    logic   commit;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign commit    = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_EXEC;
            S_EXEC: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = in_accept;
    assign o_cmd.commit  = commit;

    `GBN_ASSERT_NXT(a_accept_to_exec, in_accept, r_state == S_EXEC, "accepted item not executed")
    `GBN_ASSERT_NXT(a_commit_shows, commit, r_out_valid && r_state == S_IDLE, "commit lost")
    `GBN_ASSERT_IMP(a_no_overwrite, r_out_valid && i_out_stall, !commit, "waiting result overwritten")

endmodule

[design/go_back_n_sender_window.sv]
// top level of the go-back-n sender window
// depends on gbn_pkg, gbn_cfg, gbn_dp, gbn_ctrl
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one event per transfer:
//   a send request, an ack with its wire value (sequence plus one), or a poll
//   on which no ack came in. every event yields exactly one result transfer
//   on the output channel (o_out_valid / i_out_stall): sent flag, sent
//   sequence, packet index, timeout flag and the window base after the event.
//   an accepted event is captured, then evaluated in the execute step, and its
//   result is registered there and held valid until taken; the capture/execute
//   sequencer in gbn_ctrl takes no new event until the execute step is done.
//   o_in_stall is high only while in the execute step, so a new event is taken
//   while the previous result still waits in the output register.
//   when the receiver stalls and a result is still held, the execute step
//   waits with the captured event until the output register frees up.
//   reset (synchronous, active low) sets window size 8, timeout limit 20,
//   base, next sequence, packet index and idle count to zero and marks the
//   first window entries free; no result is pending after reset.
//   configuration: window size at byte address 0, timeout limit at 4; write
//   only while no event is in flight.
module go_back_n_sender_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // event channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [gbn_pkg::OP_W-1:0]    i_operation,
    input  logic [gbn_pkg::ACK_W-1:0]   i_ack_value,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_sent,
    output logic [gbn_pkg::SEQ_W-1:0]   o_sent_seq,
    output logic [gbn_pkg::PKT_W-1:0]   o_packet_index,
    output logic                        o_timeout_fired,
    output logic [gbn_pkg::SEQ_W-1:0]   o_window_base,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0]  paddr,
    input  logic [gbn_pkg::DATA_W-1:0]  pwdata,
    output logic [gbn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import gbn_pkg::*;

    // command path from sequencer to datapath
    t_dp_cmd          cmd;
    // live configuration values
    logic [WIN_W-1:0] window_size;
    logic [TMO_W-1:0] timeout_limit;

    // register file behind the apb-style port
    gbn_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_window_size   (window_size),
        .o_timeout_limit (timeout_limit)
    );

    // capture/execute sequencer and output-valid flag
    gbn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // window state, event evaluation and result register
    gbn_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_operation     (i_operation),
        .i_ack_value     (i_ack_value),
        .i_window_size   (window_size),
        .i_timeout_limit (timeout_limit),
        .o_sent          (o_sent),
        .o_sent_seq      (o_sent_seq),
        .o_packet_index  (o_packet_index),
        .o_timeout_fired (o_timeout_fired),
        .o_window_base   (o_window_base)
    );

endmodule

[test/tb_top.sv]
// self-checking testbench for the go-back-n sender window (go_back_n_sender_window)
// needs gbn_pkg and the design sources; directed table first, then random phases
// with random idling on both channels; results checked by predictor or typed rows
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    // operation code the block must treat as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 60;    // long receiver hold-off
    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int PHASES        = 9;
    localparam int RANDOM_EVENTS = 470;
    localparam int SHORT_PHASE   = 20;    // phase with a closed window

    // one result transfer
    typedef struct packed {
        logic             sent;
        logic [SEQ_W-1:0] seq;
        logic [PKT_W-1:0] pidx;
        logic             fired;
        logic [SEQ_W-1:0] base;
    } t_window_result;

    localparam t_window_result NO_RESULT = '0;

    typedef enum {ROW_EVENT, ROW_SET_WINDOW, ROW_SET_TIMEOUT} t_row_kind;

    // one line of the directed table; typed rows carry their own expectation
    typedef struct {
        t_row_kind        kind;
        logic [OP_W-1:0]  op;
        logic [7:0]       arg;
        int               reps;
        bit               typed;
        t_window_result   want;
    } t_stim_row;

    // clock, reset and every block input start at known values
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [OP_W-1:0]     i_operation = '0;
    logic [ACK_W-1:0]    i_ack_value = '0;
    logic                i_out_stall = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_sent;
    logic [SEQ_W-1:0]    o_sent_seq;
    logic [PKT_W-1:0]    o_packet_index;
    logic                o_timeout_fired;
    logic [SEQ_W-1:0]    o_window_base;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor state: free bitmap, window pointers, packet counter, idle polls
    logic [SEQ_COUNT-1:0] free_slots;
    logic [SEQ_W-1:0]     oldest_seq;
    logic [SEQ_W-1:0]     send_seq;
    logic [PKT_W-1:0]     pkt_next;
    logic [TMO_W-1:0]     idle_polls;
    logic [WIN_W-1:0]     win_reg;
    logic [TMO_W-1:0]     tmo_reg;

    t_window_result pending_results[$];
    t_stim_row      directed_rows[$];

    // idling knobs, percent per transfer; read by the sender task and the receiver
    int gap_pct   = 0;
    int stall_pct = 0;

    // receiver-side hold-off bookkeeping
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_left    = 0;

    // bookkeeping for the run summary and the verdict
    int failures        = 0;
    int events_done     = 0;
    int results_checked = 0;
    int packets_sent    = 0;
    int window_advances = 0;
    int timeouts_seen   = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    always #6 i_clk = ~i_clk;

    go_back_n_sender_window i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_ack_value     (i_ack_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sent          (o_sent),
        .o_sent_seq      (o_sent_seq),
        .o_packet_index  (o_packet_index),
        .o_timeout_fired (o_timeout_fired),
        .o_window_base   (o_window_base),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // advances the predictor by one event and returns the result it should produce
    function automatic t_window_result window_step(input logic [OP_W-1:0] op,
                                                   input logic [ACK_W-1:0] ack);
        t_window_result   r;
        logic [SEQ_W-1:0] in_flight;
        logic [SEQ_W-1:0] acked;
        logic [SEQ_W-1:0] offset;
        logic [TMO_W:0]   polls;
        int               span;
        int               k;
        r = '0;
        // pointer difference wraps with the sequence space
        in_flight = send_seq - oldest_seq;
        // window is clamped one below the sequence space
        span = (int'(win_reg) > SEQ_COUNT - 1) ? SEQ_COUNT - 1 : int'(win_reg);
        case (op)
            OP_SEND: begin
                if (int'(in_flight) < span && free_slots[send_seq]) begin
                    r.sent = 1'b1;
                    r.seq  = send_seq;
                    r.pidx = pkt_next;
                    free_slots[send_seq] = 1'b0;
                    send_seq = send_seq + 1'b1;
                    pkt_next = pkt_next + 1'b1;
                    packets_sent++;
                end
            end
            OP_ACK: begin
                // any ack counts as link activity, even one that is dropped
                idle_polls = '0;
                if (ack >= 1 && ack <= SEQ_COUNT) begin
                    acked  = SEQ_W'(ack - 1'b1);
                    offset = acked - oldest_seq;
                    // only acks naming an outstanding sequence move the base
                    if (offset < in_flight) begin
                        for (k = 0; k <= int'(offset); k++) begin
                            free_slots[SEQ_W'(int'(oldest_seq) + k)] = 1'b1;
                        end
                        oldest_seq = acked + 1'b1;
                        window_advances++;
                    end
                end
            end
            OP_POLL: begin
                polls = {1'b0, idle_polls} + 1'b1;
                if (polls > {1'b0, tmo_reg}) begin
                    // go back: refresh the window and rewind by what is in flight
                    r.fired = 1'b1;
                    for (k = 0; k < span; k++) begin
                        free_slots[SEQ_W'(int'(oldest_seq) + k)] = 1'b1;
                    end
                    pkt_next   = pkt_next - PKT_W'(in_flight);
                    send_seq   = oldest_seq;
                    idle_polls = '0;
                    timeouts_seen++;
                end else begin
                    idle_polls = polls[TMO_W-1:0];
                end
            end
            default: begin
                // unused code leaves all state alone
            end
        endcase
        r.base = oldest_seq;
        return r;
    endfunction

    function automatic t_window_result res(input logic sent, input logic [SEQ_W-1:0] seq,
                                           input logic [PKT_W-1:0] pidx, input logic fired,
                                           input logic [SEQ_W-1:0] base);
        t_window_result r;
        r.sent  = sent;
        r.seq   = seq;
        r.pidx  = pidx;
        r.fired = fired;
        r.base  = base;
        return r;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [OP_W-1:0] op,
                                    input logic [7:0] arg, input int reps, input bit typed,
                                    input t_window_result want);
        t_stim_row row;
        row.kind  = kind;
        row.op    = op;
        row.arg   = arg;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // offers one event, possibly after a short gap, and records the expected
    // result at the edge where the transfer happens
    task automatic push_event(input logic [OP_W-1:0] op, input logic [ACK_W-1:0] ack,
                              input bit typed, input t_window_result want);
        t_window_result predicted;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_ack_value <= ack;
        do @(posedge i_clk); while (o_in_stall);
        predicted = window_step(op, ack);
        pending_results.push_back(typed ? want : predicted);
        events_done++;
    endtask

    // mostly well-formed traffic: sends, acks of outstanding sequences, polls;
    // the rest is stray acks and the unused operation code
    task automatic random_event();
        logic [OP_W-1:0]  op;
        logic [ACK_W-1:0] ack;
        logic [SEQ_W-1:0] in_flight;
        int               pick;
        pick      = $urandom_range(0, 99);
        ack       = ACK_W'($urandom_range(0, 31));
        in_flight = send_seq - oldest_seq;
        if (pick < 42) begin
            op = OP_SEND;
        end else if (pick < 72) begin
            op = OP_ACK;
            if (in_flight != 0 && $urandom_range(0, 4) != 0) begin
                ack = ACK_W'(SEQ_W'(int'(oldest_seq) + $urandom_range(0, in_flight - 1)))
                      + 1'b1;
            end
        end else if (pick < 96) begin
            op = OP_POLL;
        end else begin
            op = OP_UNUSED;
        end
        push_event(op, ack, 1'b0, NO_RESULT);
    endtask

    // sender pause: stop offering and let every expected result come out
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // setup then access phase; psel is left high so writes can go back to back,
    // the caller drops it after the last one
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        if (idx == REG_WINDOW) begin
            win_reg = value[WIN_W-1:0];
        end else begin
            tmo_reg = value[TMO_W-1:0];
        end
        settings_used++;
    endtask

    task automatic check_result();
        t_window_result want;
        if (pending_results.size() == 0) begin
            $error("result transfer with no event pending");
            failures++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (o_sent !== want.sent) begin
            $error("sent: expected %0d, got %0d", want.sent, o_sent);
            failures++;
        end
        if (o_sent_seq !== want.seq) begin
            $error("sent_seq: expected %0d, got %0d", want.seq, o_sent_seq);
            failures++;
        end
        if (o_packet_index !== want.pidx) begin
            $error("packet_index: expected %0d, got %0d", want.pidx, o_packet_index);
            failures++;
        end
        if (o_timeout_fired !== want.fired) begin
            $error("timeout_fired: expected %0d, got %0d", want.fired, o_timeout_fired);
            failures++;
        end
        if (o_window_base !== want.base) begin
            $error("window_base: expected %0d, got %0d", want.base, o_window_base);
            failures++;
        end
    endtask

    // receiver: checks each result transfer, then decides the next stall;
    // a hold-off request from the main sequence wins over random stall bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_result();
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 5) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog: any accepted transfer or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (psel && penable && pready) || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int             phase;
        int             n;
        int             count;
        int             directed_events;
        logic [WIN_W-1:0] win;
        logic [TMO_W-1:0] tmo;

        // predictor after reset: window 8, limit 20, first window entries free
        win_reg    = WINDOW_RESET;
        tmo_reg    = TIMEOUT_RESET;
        free_slots = '0;
        for (n = 0; n < int'(WINDOW_RESET); n++) begin
            free_slots[n] = 1'b1;
        end
        oldest_seq = '0;
        send_seq   = '0;
        pkt_next   = '0;
        idle_polls = '0;

        // directed table; typed rows are the ones readable straight off the spec
        add_row(ROW_EVENT, OP_SEND, 0, 1, 1'b1, res(1, 0, 0, 0, 0));   // first send
        add_row(ROW_EVENT, OP_SEND, 0, 2, 1'b0, NO_RESULT);
        add_row(ROW_EVENT, OP_ACK, 0, 1, 1'b1, res(0, 0, 0, 0, 0));    // ack zero dropped
        add_row(ROW_EVENT, OP_ACK, 31, 1, 1'b1, res(0, 0, 0, 0, 0));   // past the space
        add_row(ROW_EVENT, OP_ACK, 2, 1, 1'b1, res(0, 0, 0, 0, 2));    // cumulative ack
        add_row(ROW_EVENT, OP_UNUSED, 16, 1, 1'b1, res(0, 0, 0, 0, 2)); // no-op code
        add_row(ROW_SET_TIMEOUT, OP_SEND, 0, 1, 1'b0, NO_RESULT);
        add_row(ROW_EVENT, OP_POLL, 0, 1, 1'b1, res(0, 0, 0, 1, 2));   // zero limit fires
        add_row(ROW_EVENT, OP_SEND, 0, 1, 1'b1, res(1, 2, 2, 0, 2));   // resend after rewind
        add_row(ROW_SET_TIMEOUT, OP_SEND, 255, 1, 1'b0, NO_RESULT);
        add_row(ROW_EVENT, OP_POLL, 0, 1, 1'b1, res(0, 0, 0, 0, 2));
        add_row(ROW_SET_WINDOW, OP_SEND, 0, 1, 1'b0, NO_RESULT);
        add_row(ROW_EVENT, OP_SEND, 0, 1, 1'b1, res(0, 0, 0, 0, 2));   // closed window
        add_row(ROW_SET_WINDOW, OP_SEND, 15, 1, 1'b0, NO_RESULT);
        add_row(ROW_SET_TIMEOUT, OP_SEND, 1, 1, 1'b0, NO_RESULT);
        add_row(ROW_EVENT, OP_POLL, 0, 1, 1'b0, NO_RESULT);            // refresh full window
        add_row(ROW_EVENT, OP_SEND, 0, 16, 1'b0, NO_RESULT);           // fill, last one blocked
        add_row(ROW_EVENT, OP_ACK, 16, 1, 1'b0, NO_RESULT);            // ack of sequence 15
        add_row(ROW_EVENT, OP_ACK, 1, 1, 1'b0, NO_RESULT);             // wrap past zero

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_EVENT) begin
                repeat (directed_rows[r].reps) begin
                    push_event(directed_rows[r].op, directed_rows[r].arg[ACK_W-1:0],
                               directed_rows[r].typed, directed_rows[r].want);
                end
            end else begin
                wait_results();
                cfg_write(directed_rows[r].kind == ROW_SET_WINDOW ? REG_WINDOW : REG_TIMEOUT,
                          DATA_W'(directed_rows[r].arg));
                psel <= 1'b0;
            end
        end
        directed_events = events_done;

        // random phases; the first few pin the register extremes
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    win = 4'd15;
                    tmo = 8'd255;
                end
                1: begin
                    win = 4'd1;
                    tmo = 8'd0;
                end
                2: begin
                    win = 4'd0;
                    tmo = 8'd3;
                end
                3: begin
                    win = 4'd8;
                    tmo = 8'd6;
                end
                default: begin
                    win = WIN_W'($urandom_range(1, 15));
                    tmo = $urandom_range(0, 1) ? TMO_W'($urandom_range(0, 8))
                                               : TMO_W'($urandom_range(0, 255));
                end
            endcase
            wait_results();
            cfg_write(REG_WINDOW, DATA_W'(win));
            cfg_write(REG_TIMEOUT, DATA_W'(tmo));
            psel <= 1'b0;

            // idling mix per phase, none at all in the last one
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 20 * $urandom_range(0, 2);
                stall_pct = 20 * $urandom_range(0, 2);
            end

            // long receiver hold-off while the sender keeps offering, so the
            // block fills up and stalls its input
            if (phase == 3) begin
                gap_pct = 0;
                hold_requests <= hold_requests + 1;
            end

            count = (phase == 2) ? SHORT_PHASE
                                 : (RANDOM_EVENTS - SHORT_PHASE) / (PHASES - 1);
            for (n = 0; n < count; n++) begin
                if (phase == 4 && n == count / 2) begin
                    wait_results();
                end
                random_event();
            end
        end

        wait_results();

        $display("covered %0d events (%0d directed) across %0d register writes",
                 events_done, directed_events, settings_used);
        $display("%0d packets sent, %0d base advances, %0d timeouts, %0d results checked",
                 packets_sent, window_advances, timeouts_seen, results_checked);
        if (failures == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
